### src/dss_pkg.sv
`timescale 1ns / 1ps
package dss_pkg;

  localparam int DEF_SAMPLE_BITS   = 16;
  localparam int DEF_FRACTION_BITS = 8;
  localparam int COUNT_BITS        = 16;
  // arithmetic width of the variance numerator and the scaled variance
  localparam int WIDE_BITS         = 64;
  localparam int QUEUE_DEPTH       = 2;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t GROUP_SIZE_RESET = count_t'(16);

  // running sum never wraps: at most 2^16 samples per group
  function automatic int sum_bits(input int sample_bits);
    return sample_bits + COUNT_BITS;
  endfunction

  // square sum width is capped at the wide width, where it can wrap
  function automatic int sq_bits(input int sample_bits);
    int w;
    w = 2 * sample_bits + COUNT_BITS;
    return (w > WIDE_BITS) ? WIDE_BITS : w;
  endfunction

  // summary word: {count, max, min, square sum, sum}
  function automatic int summary_bits(input int sample_bits);
    return sum_bits(sample_bits) + sq_bits(sample_bits) + 2 * sample_bits + COUNT_BITS;
  endfunction

endpackage

### src/dss_front.sv
`timescale 1ns / 1ps
module dss_front #(
  parameter int SAMPLE_BITS = dss_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  dss_pkg::count_t                                 group_size,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]                   sample,
  input  logic                                            sample_ok,
  output logic                                            push,
  output logic [dss_pkg::summary_bits(SAMPLE_BITS)-1:0]   summary,
  input  logic                                            queue_ready
);

  localparam int SUM_W = dss_pkg::sum_bits(SAMPLE_BITS);
  localparam int SQ_W  = dss_pkg::sq_bits(SAMPLE_BITS);

  localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  dss_pkg::count_t                position;
  logic signed [SUM_W-1:0]        run_sum;
  logic [SQ_W-1:0]                run_sq;
  logic signed [SAMPLE_BITS-1:0]  run_min;
  logic signed [SAMPLE_BITS-1:0]  run_max;
  dss_pkg::count_t                tally;

  dss_pkg::count_t                position_next;
  dss_pkg::count_t                size_eff;
  logic signed [SUM_W-1:0]        run_sum_next;
  logic [SQ_W-1:0]                run_sq_next;
  logic signed [SAMPLE_BITS-1:0]  run_min_next;
  logic signed [SAMPLE_BITS-1:0]  run_max_next;
  dss_pkg::count_t                tally_next;
  logic [SAMPLE_BITS-1:0]         mag;
  logic [2*SAMPLE_BITS-1:0]       sq_term;
  logic                           accept;
  logic                           last;

  assign in_ready = queue_ready;
  assign accept   = in_valid && queue_ready;

  always_comb begin
    mag           = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    sq_term       = mag * mag;
    run_sum_next  = run_sum;
    run_sq_next   = run_sq;
    run_min_next  = run_min;
    run_max_next  = run_max;
    tally_next    = tally;
    if (sample_ok) begin
      run_sum_next = run_sum + SUM_W'(sample);
      run_sq_next  = run_sq + SQ_W'(sq_term);
      run_min_next = (sample < run_min) ? sample : run_min;
      run_max_next = (sample > run_max) ? sample : run_max;
      tally_next   = tally + dss_pkg::count_t'(1);
    end
    position_next = position + dss_pkg::count_t'(1);
    size_eff      = (group_size == '0) ? dss_pkg::count_t'(1) : group_size;
    last          = (position_next >= size_eff);
  end

  assign push    = accept && last;
  assign summary = {tally_next, run_max_next, run_min_next, run_sq_next, run_sum_next};

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      position <= '0;
      run_sum  <= '0;
      run_sq   <= '0;
      run_min  <= MOST_POS;
      run_max  <= MOST_NEG;
      tally    <= '0;
    end else if (accept) begin
      position <= position_next;
      run_sum  <= run_sum_next;
      run_sq   <= run_sq_next;
      run_min  <= run_min_next;
      run_max  <= run_max_next;
      tally    <= tally_next;
    end
  end

endmodule

### src/dss_queue.sv
`timescale 1ns / 1ps
module dss_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dss_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

### src/dss_back.sv
`timescale 1ns / 1ps
module dss_back #(
  parameter int SAMPLE_BITS   = dss_pkg::DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = dss_pkg::DEF_FRACTION_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_valid,
  input  logic [dss_pkg::summary_bits(SAMPLE_BITS)-1:0] q_data,
  output logic                                          q_pop,
  output logic                                          res_valid,
  input  logic                                          res_ready,
  output logic [SAMPLE_BITS+FRACTION_BITS-1:0]          res_mean,
  output logic [SAMPLE_BITS-1:0]                        res_min,
  output logic [SAMPLE_BITS-1:0]                        res_max,
  output logic [SAMPLE_BITS+FRACTION_BITS-1:0]          res_std,
  output dss_pkg::count_t                               res_count,
  output logic                                          res_empty
);

  localparam int SUM_W     = dss_pkg::sum_bits(SAMPLE_BITS);
  localparam int SQ_W      = dss_pkg::sq_bits(SAMPLE_BITS);
  localparam int CW        = dss_pkg::COUNT_BITS;
  localparam int W         = dss_pkg::WIDE_BITS;
  localparam int STAT_W    = SAMPLE_BITS + FRACTION_BITS;
  localparam int NUM_W     = SUM_W + FRACTION_BITS;
  localparam int DVS_W     = 2 * CW;
  localparam int REM_W     = DVS_W + 1;
  localparam int DIV_STEPS = W + 2 * FRACTION_BITS;
  localparam int ROOT_W    = W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MEAN = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_PROD = 3'd4;
  localparam logic [2:0] ST_VAR  = 3'd5;
  localparam logic [2:0] ST_ROOT = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]                    state;
  logic [CNT_W-1:0]              cnt;

  logic signed [SUM_W-1:0]       w_sum;
  logic [SQ_W-1:0]               w_sq;
  logic [SAMPLE_BITS-1:0]        w_min;
  logic [SAMPLE_BITS-1:0]        w_max;
  dss_pkg::count_t               w_n;
  logic [DVS_W-1:0]              w_n2;
  logic [STAT_W-1:0]             mean_r;
  logic [W-1:0]                  sumsq_r;

  // shared restoring divider
  logic [W-1:0]                  dvd;
  logic [DVS_W-1:0]              dvs;
  logic [DVS_W-1:0]              drem;
  logic [W-1:0]                  dq;
  // shared shift-add multiplier
  logic [W-1:0]                  macc;
  logic [W-1:0]                  ma;
  logic [SUM_W-1:0]              mb;
  // digit-by-digit root, consumes dq two bits a step
  logic [ROOT_W+1:0]             rrem;
  logic [ROOT_W-1:0]             rroot;

  logic                          neg;
  logic [SUM_W-1:0]              abs_sum;
  logic [NUM_W-1:0]              abs_num;
  logic [REM_W-1:0]              div_trial;
  logic                          div_ge;
  logic [DVS_W-1:0]              div_rem_next;
  logic [W-1:0]                  mul_sum;
  logic [ROOT_W+3:0]             root_sh;
  logic [ROOT_W+3:0]             root_try;
  logic                          root_ge;
  logic [STAT_W-1:0]             mean_fix;
  logic [W-1:0]                  var_num;
  logic                          load_out;

  always_comb begin
    neg          = w_sum[SUM_W-1];
    abs_sum      = neg ? SUM_W'(-w_sum) : SUM_W'(w_sum);
    abs_num      = NUM_W'(abs_sum) << FRACTION_BITS;
    div_trial    = {drem, dvd[W-1]};
    div_ge       = (div_trial >= {1'b0, dvs});
    div_rem_next = div_ge ? DVS_W'(div_trial - {1'b0, dvs}) : DVS_W'(div_trial);
    mul_sum      = macc + (mb[0] ? ma : '0);
    root_sh      = {rrem, dq[W-1:W-2]};
    root_try     = (ROOT_W+4)'({rroot, 2'b01});
    root_ge      = (root_sh >= root_try);
    // floor for negative sums: one less when the division leaves a remainder
    mean_fix     = neg ? STAT_W'(STAT_W'(0) - STAT_W'(dq) - STAT_W'(drem != '0))
                       : STAT_W'(dq);
    var_num      = (mul_sum >= sumsq_r) ? mul_sum - sumsq_r : '0;
  end

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign load_out = (state == ST_DONE) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          state <= (w_n == '0) ? ST_DONE : ST_MEAN;
          cnt   <= CNT_W'(NUM_W - 1);
        end
        ST_MEAN: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_SQR;
            cnt   <= CNT_W'(SUM_W - 1);
          end
        end
        ST_SQR: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_PROD;
            cnt   <= CNT_W'(CW - 1);
          end
        end
        ST_PROD: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_VAR;
            cnt   <= CNT_W'(DIV_STEPS - 1);
          end
        end
        ST_VAR: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_ROOT;
            cnt   <= CNT_W'(ROOT_W - 1);
          end
        end
        ST_ROOT: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        w_sum <= $signed(q_data[SUM_W-1:0]);
        w_sq  <= q_data[SUM_W +: SQ_W];
        w_min <= q_data[SUM_W+SQ_W +: SAMPLE_BITS];
        w_max <= q_data[SUM_W+SQ_W+SAMPLE_BITS +: SAMPLE_BITS];
        w_n   <= q_data[SUM_W+SQ_W+2*SAMPLE_BITS +: CW];
      end
      ST_PREP: begin
        w_n2   <= DVS_W'(w_n) * DVS_W'(w_n);
        dvd    <= W'(abs_num) << (W - NUM_W);
        dvs    <= DVS_W'(w_n);
        drem   <= '0;
        dq     <= '0;
        mean_r <= '0;
        rroot  <= '0;
      end
      ST_MEAN: begin
        dvd  <= dvd << 1;
        drem <= div_rem_next;
        dq   <= {dq[W-2:0], div_ge};
        if (cnt == '0) begin
          ma   <= W'(abs_sum);
          mb   <= abs_sum;
          macc <= '0;
        end
      end
      ST_SQR: begin
        macc <= mul_sum;
        ma   <= ma << 1;
        mb   <= mb >> 1;
        if (cnt == '0) begin
          sumsq_r <= mul_sum;
          ma      <= W'(w_sq);
          mb      <= SUM_W'(w_n);
          macc    <= '0;
        end
      end
      ST_PROD: begin
        macc <= mul_sum;
        ma   <= ma << 1;
        mb   <= mb >> 1;
        if (cnt == '0) begin
          mean_r <= mean_fix;
          dvd    <= var_num;
          dvs    <= w_n2;
          drem   <= '0;
          dq     <= '0;
        end
      end
      ST_VAR: begin
        // dq keeps the low bits of the quotient, zeros shift in past the numerator
        dvd  <= dvd << 1;
        drem <= div_rem_next;
        dq   <= {dq[W-2:0], div_ge};
        if (cnt == '0) begin
          rrem  <= '0;
          rroot <= '0;
        end
      end
      ST_ROOT: begin
        rrem  <= root_ge ? (ROOT_W+2)'(root_sh - root_try) : (ROOT_W+2)'(root_sh);
        rroot <= {rroot[ROOT_W-2:0], root_ge};
        dq    <= dq << 2;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_empty <= (w_n == '0);
      res_count <= w_n;
      res_mean  <= mean_r;
      res_std   <= STAT_W'(rroot);
      res_min   <= (w_n == '0) ? '0 : w_min;
      res_max   <= (w_n == '0) ? '0 : w_max;
    end
  end

endmodule

### src/decimating_sample_statistics.sv
`timescale 1ns / 1ps
// min / max / mean / standard deviation over fixed-size groups of samples
//
// s_t* carries one sample per request, tuser flags it valid; invalid samples
// still count toward the group length. cfg_* writes group_size (0 acts as 1);
// write it only while the block is idle. m_t* gives one summary per finished
// group; an empty group has tuser set and all stat fields zero.
//
// the front accumulates one sample per cycle while the queue has room and
// hands each finished group to a two-entry summary queue. the back works one
// summary at a time with a shared bit-serial divider, a shift-add multiplier
// and a digit root: it divides for the mean, squares the sum, multiplies the
// square sum by the count, divides for the variance and takes the root;
// empty groups skip straight to the output. groups that arrive faster than
// the back takes summaries back up into s_tready once the queue is full.
// a stalled m_tready holds the result in the output register while the
// back finishes the next summary and the queue keeps filling.
// reset (synchronous) drops any partial group, empties the queue and sets
// group_size to 16.
module decimating_sample_statistics #(
  parameter int SAMPLE_BITS   = dss_pkg::DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = dss_pkg::DEF_FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  dss_pkg::count_t           cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // sample_ok
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // mean_q8, min_value, max_value, std_q8, valid_count
  output logic [((2*(SAMPLE_BITS+FRACTION_BITS)+2*SAMPLE_BITS+dss_pkg::COUNT_BITS+7)/8)*8-1:0]
                                    m_tdata,
  // group_empty
  output logic                      m_tuser
);

  localparam int STAT_W    = SAMPLE_BITS + FRACTION_BITS;
  localparam int SUMMARY_W = dss_pkg::summary_bits(SAMPLE_BITS);
  localparam int OUT_W     =
    ((2*STAT_W + 2*SAMPLE_BITS + dss_pkg::COUNT_BITS + 7) / 8) * 8;

  dss_pkg::count_t         group_size;
  logic                    push;
  logic [SUMMARY_W-1:0]    push_data;
  logic                    queue_ready;
  logic                    q_valid;
  logic                    q_pop;
  logic [SUMMARY_W-1:0]    q_data;
  logic [STAT_W-1:0]       res_mean;
  logic [STAT_W-1:0]       res_std;
  logic [SAMPLE_BITS-1:0]  res_min;
  logic [SAMPLE_BITS-1:0]  res_max;
  dss_pkg::count_t         res_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= dss_pkg::GROUP_SIZE_RESET;
    end else if (cfg_valid) begin
      group_size <= cfg_data;
    end
  end

  dss_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .group_size  (group_size),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .sample      (s_tdata[SAMPLE_BITS-1:0]),
    .sample_ok   (s_tuser),
    .push        (push),
    .summary     (push_data),
    .queue_ready (queue_ready)
  );

  dss_queue #(
    .WIDTH (SUMMARY_W),
    .DEPTH (dss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (queue_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  dss_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_mean  (res_mean),
    .res_min   (res_min),
    .res_max   (res_max),
    .res_std   (res_std),
    .res_count (res_count),
    .res_empty (m_tuser)
  );

  assign m_tdata = OUT_W'({res_count, res_std, res_max, res_min, res_mean});

endmodule
